// ===== rtl/asu_pkg.sv =====
// Shared widths and types for the angle sequence unwrapper.
// No dependencies; used by asu_rem_unit and angle_sequence_unwrapper_unit.
`timescale 1ns / 1ps

package asu_pkg;

   localparam int ANGLE_W   = 16;                   // angle sample width
   localparam int FULL_W    = 17;                   // full-turn register width
   localparam int MAG_W     = 17;                   // magnitude of a signed difference
   localparam int STEP_CNT  = MAG_W;                // one quotient bit per cycle
   localparam int STEP_W    = $clog2(STEP_CNT);
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [ADDR_W-1:0] ADDR_FULL_TURN = 3'd0;
   localparam logic [FULL_W-1:0] FULL_TURN_RESET = 17'h10000;

   // Status from the remainder unit back to the sequencer
   typedef struct packed {
      logic busy;
      logic done;
   } rem_status_type;

endpackage

// ===== rtl/asu_rem_unit.sv =====
// Restoring remainder unit: one dividend bit per cycle, all 17 dividend bits per operation.
// Depends on asu_pkg.
`timescale 1ns / 1ps

module asu_rem_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [asu_pkg::MAG_W-1:0]   dividend,
   input  logic [asu_pkg::FULL_W-1:0]  modulus,
   output logic [asu_pkg::FULL_W-1:0]  remainder,
   output asu_pkg::rem_status_type     status
);

   logic [asu_pkg::MAG_W-1:0]  dvd_ff, dvd_in;
   logic [asu_pkg::FULL_W-1:0] rem_ff, rem_in;
   logic [asu_pkg::FULL_W-1:0] mod_ff, mod_in;
   logic [asu_pkg::STEP_W-1:0] cnt_ff, cnt_in;
   logic                       busy_ff, busy_in;
   logic                       done_ff, done_in;
   logic [asu_pkg::FULL_W:0]   trial;
   logic [asu_pkg::FULL_W+1:0] diff;

   // Shift next dividend bit into the partial remainder and try the subtract
   assign trial = {rem_ff, dvd_ff[asu_pkg::MAG_W-1]};
   assign diff  = {1'b0, trial} - {2'b00, mod_ff};

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      mod_in  = mod_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         mod_in  = modulus;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[asu_pkg::MAG_W-2:0], 1'b0};
         // restore when the trial subtract borrows
         rem_in = diff[asu_pkg::FULL_W+1] ? trial[asu_pkg::FULL_W-1:0]
                                          : diff[asu_pkg::FULL_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == asu_pkg::STEP_W'(asu_pkg::STEP_CNT - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      mod_ff <= mod_in;
   end

   assign remainder   = rem_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

// ===== rtl/angle_sequence_unwrapper_unit.sv =====
// Angle sequence unwrapper: an accepted sample passes the remainder steps (ST_DIV),
// the hand-off, the sign fix (ST_FIX) and wrap and add (ST_WRAP); a zero full turn goes
// straight to ST_WRAP. No new sample is taken until the last has left ST_WRAP, which waits
// while the output is held. A waiting result does not block acceptance of the next sample.
// Synchronous reset: full turn 65536, previous angle 0, no result pending.
// Depends on asu_pkg and asu_rem_unit.
`timescale 1ns / 1ps

module angle_sequence_unwrapper_unit (
   input  logic                              clock,
   input  logic                              reset,
   // input channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [asu_pkg::ANGLE_W-1:0] req_angle_in,
   input  logic                              req_first_sample,
   // result channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [asu_pkg::ANGLE_W-1:0] rsp_angle_out,
   // configuration
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [asu_pkg::ADDR_W-1:0]        paddr,
   input  logic [asu_pkg::DATA_W-1:0]        pwdata,
   output logic [asu_pkg::DATA_W-1:0]        prdata,
   output logic                              pready
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_FIX  = 2'd2;
   localparam logic [1:0] ST_WRAP = 2'd3;

   logic [1:0]                  state_ff, state_in;
   logic [asu_pkg::FULL_W-1:0]  full_turn_ff, full_turn_in;
   logic [asu_pkg::ANGLE_W-1:0] prev_ff, prev_in;
   logic [asu_pkg::ANGLE_W-1:0] sample_ff, sample_in;
   logic                        first_ff, first_in;
   logic                        neg_ff, neg_in;
   logic                        zero_ff, zero_in;
   logic [asu_pkg::FULL_W-1:0]  mod_ff, mod_in;
   logic [asu_pkg::FULL_W-1:0]  red_ff, red_in;
   logic                        out_valid_ff, out_valid_in;
   logic [asu_pkg::ANGLE_W-1:0] out_ff, out_in;

   logic                        req_accept;
   logic                        out_free;
   logic [asu_pkg::FULL_W-1:0]  modulus;
   logic [asu_pkg::MAG_W:0]     diff;
   logic [asu_pkg::MAG_W-1:0]   magnitude;
   logic                        rem_start;
   logic [asu_pkg::FULL_W-1:0]  rem_value;
   asu_pkg::rem_status_type     rem_status;
   logic [asu_pkg::FULL_W-1:0]  wrapped;
   logic [asu_pkg::ANGLE_W-1:0] result;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !out_valid_ff || !rsp_stall;

   // Bit 0 of the full turn is ignored
   assign modulus = {full_turn_ff[asu_pkg::FULL_W-1:1], 1'b0};

   // Signed value to reduce: the sample itself, or its difference from the last output
   assign diff = req_first_sample
               ? {{(asu_pkg::MAG_W+1-asu_pkg::ANGLE_W){req_angle_in[asu_pkg::ANGLE_W-1]}},
                  req_angle_in}
               : {{(asu_pkg::MAG_W+1-asu_pkg::ANGLE_W){req_angle_in[asu_pkg::ANGLE_W-1]}},
                  req_angle_in}
                 - {{(asu_pkg::MAG_W+1-asu_pkg::ANGLE_W){prev_ff[asu_pkg::ANGLE_W-1]}},
                  prev_ff};
   assign magnitude = diff[asu_pkg::MAG_W] ? asu_pkg::MAG_W'(-diff)
                                           : diff[asu_pkg::MAG_W-1:0];

   assign rem_start = req_accept && (modulus != '0);

   asu_rem_unit u_rem (
      .clock     (clock),
      .reset     (reset),
      .start     (rem_start),
      .dividend  (magnitude),
      .modulus   (modulus),
      .remainder (rem_value),
      .status    (rem_status)
   );

   // Wrap into (-half, half] and add to the previous output, except for a first sample or a zero full turn
   always_comb begin
      wrapped = red_ff;
      if (!first_ff && (red_ff > {1'b0, mod_ff[asu_pkg::FULL_W-1:1]})) begin
         wrapped = red_ff - mod_ff;
      end
      if (zero_ff) begin
         result = sample_ff;
      end else if (first_ff) begin
         result = red_ff[asu_pkg::ANGLE_W-1:0];
      end else begin
         result = prev_ff + wrapped[asu_pkg::ANGLE_W-1:0];
      end
   end

   // Sequencer
   always_comb begin
      state_in     = state_ff;
      sample_in    = sample_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      mod_in       = mod_ff;
      red_in       = red_ff;
      prev_in      = prev_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && rsp_stall;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               sample_in = req_angle_in;
               first_in  = req_first_sample;
               neg_in    = diff[asu_pkg::MAG_W];
               zero_in   = (modulus == '0);
               mod_in    = modulus;
               state_in  = (modulus == '0) ? ST_WRAP : ST_DIV;
            end
         end
         ST_DIV: begin
            if (rem_status.done) begin
               state_in = ST_FIX;
            end
         end
         ST_FIX: begin
            // Negative operand: bring a non-zero remainder into [0, full)
            red_in   = (neg_ff && (rem_value != '0)) ? mod_ff - rem_value : rem_value;
            state_in = ST_WRAP;
         end
         ST_WRAP: begin
            if (out_free) begin
               out_in       = result;
               out_valid_in = 1'b1;
               prev_in      = result;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Configuration write
   always_comb begin
      full_turn_in = full_turn_ff;
      if (psel && penable && pwrite && pready && (paddr == asu_pkg::ADDR_FULL_TURN)) begin
         full_turn_in = pwdata[asu_pkg::FULL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         full_turn_ff <= asu_pkg::FULL_TURN_RESET;
         prev_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         full_turn_ff <= full_turn_in;
         prev_ff      <= prev_in;
         out_valid_ff <= out_valid_in;
      end
      sample_ff <= sample_in;
      first_ff  <= first_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      mod_ff    <= mod_in;
      red_ff    <= red_in;
      out_ff    <= out_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_angle_out = out_ff;
   assign pready        = 1'b1;
   assign prdata        = (paddr == asu_pkg::ADDR_FULL_TURN)
                        ? {{(asu_pkg::DATA_W-asu_pkg::FULL_W){1'b0}}, full_turn_ff}
                        : '0;

`ifndef ASSERT_OFF
   // A fresh result is always the value kept for the next difference
   a_prev_tracks_out: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> (prev_ff == out_ff))
      else $error("previous angle does not match new result");

   // Remainder unit finishes only while the sequencer waits for it
   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> (state_ff == ST_DIV))
      else $error("remainder done outside division phase");

   // Reduced value stays below the modulus
   a_rem_range: assert property (@(posedge clock) disable iff (reset)
      rem_status.done |-> (rem_value < mod_ff))
      else $error("remainder not below modulus");

   // No new sample is taken while the remainder unit is running
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rem_status.busy |-> !req_accept)
      else $error("sample accepted during remainder operation");
`endif

endmodule
